@@ rtl/point_set_extreme_projection_distance_macros.svh @@
// Assertion macros shared by the point set extreme projection and distance block.
// Each macro expands to a concurrent assertion clocked on clk and disabled in reset (rst_n).
`ifndef POINT_SET_EXTREME_PROJECTION_DISTANCE_MACROS_SVH
`define POINT_SET_EXTREME_PROJECTION_DISTANCE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PSPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define PSPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define PSPD_ASSERT_IMPL(lbl, ante, cons)
`define PSPD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/pspd_pkg.sv @@
// Package for the point set extreme projection and distance block.
// Holds sizes, codes, start values and the root unit result type; depends on nothing.
`timescale 1ns / 1ps

package pspd_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int COORD_W    = 16;
  localparam int MUL_W      = COORD_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int PROJ_W     = 33;
  localparam int MINPROJ_W  = 32;
  localparam int DMIN_W     = 23;
  localparam int ROOT_W     = 17;
  localparam int SQ_W       = 2 * ROOT_W;
  localparam int MIN_DIST_W = 12;
  localparam int PCNT_W     = 7;

  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [CFG_AW-3:0] REG_POINT_COUNT = '0;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic signed [PROJ_W-1:0] PROJ_START_MIN = 33'sd6553600;
  localparam logic signed [PROJ_W-1:0] PROJ_START_MAX = -33'sd6553600;
  localparam logic [DMIN_W-1:0]        DIST_START_MIN = 23'd6553600;
  localparam logic [MIN_DIST_W-1:0]    MIN_DIST_LIMIT = 12'd2560;

  localparam logic [SQ_W-1:0] SQ_BIT0 = SQ_W'(1) << (2 * (ROOT_W - 1));

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sq_result_t;

endpackage

@@ rtl/point_set_extreme_projection_distance.sv @@
// Top level of the point set extreme projection and distance block.
// Depends on pspd_pkg, pspd_ram, pspd_sqrt and the assertion macro header.
`timescale 1ns / 1ps
`include "point_set_extreme_projection_distance_macros.svh"

// The block keeps a table of up to 64 points in signed Q8.8 and answers queries
// about it. A transaction is accepted on a rising edge where start is high and
// busy is low. A load transaction (op 0) writes one table slot in that same edge
// and gives no result; busy stays low, so loads can follow each other in every
// cycle. A query transaction (op 1) raises busy and, over the first point_count
// points, finds the smallest and largest dot product with the probe and the
// truncated square roots of the smallest and largest squared distance. The answer
// appears on the out_ ports for exactly one cycle, marked by out_valid; there is
// no way to stall it, so the receiver must capture it in that cycle. A query
// takes n = point_count capped at 64 points, each through a product state and a
// squared-difference state, then a drain state and the two square roots before
// the out_valid cycle. busy falls in the out_valid cycle, so the next transaction
// can be accepted at the edge that ends it. Each point makes two passes through
// one shared pair of 17x17 signed multipliers (products, then squared
// differences), and the two square roots run one after the other through a
// single root unit that produces one result bit per cycle.
// point_count is written through the APB-style port at byte address 0 and must
// only be written while busy is low and no query result is pending. Table entries
// read by a query must have been loaded beforehand.
module point_set_extreme_projection_distance import pspd_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_AW-1:0]            paddr,
  input  logic [CFG_DW-1:0]            pwdata,
  output logic [CFG_DW-1:0]            prdata,
  output logic                         pready,
  // Input channel.
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic [5:0]                   in_point_index,
  input  logic signed [COORD_W-1:0]    in_point_x,
  input  logic signed [COORD_W-1:0]    in_point_y,
  input  logic signed [COORD_W-1:0]    in_query_x,
  input  logic signed [COORD_W-1:0]    in_query_y,
  // Result channel.
  output logic                         out_valid,
  output logic signed [MINPROJ_W-1:0]  out_proj_lo,
  output logic signed [PROJ_W-1:0]     out_proj_hi,
  output logic [MIN_DIST_W-1:0]        out_dist_lo,
  output logic [ROOT_W-1:0]            out_dist_hi
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DRAIN,
    S_SQMIN,
    S_SQMAX
  } state_t;

  state_t                      state_r;
  logic [PCNT_W-1:0]           point_count_r;
  logic [CNT_W-1:0]            n_r;
  logic [CNT_W-1:0]            n_nxt;
  logic [CNT_W-1:0]            idx_r;
  logic signed [COORD_W-1:0]   qx_r;
  logic signed [COORD_W-1:0]   qy_r;
  logic signed [MUL_W-1:0]     dx_r;
  logic signed [MUL_W-1:0]     dy_r;
  logic signed [PROD_W-1:0]    prod0_r;
  logic signed [PROD_W-1:0]    prod1_r;
  logic signed [PROJ_W-1:0]    proj_r;
  logic signed [PROJ_W-1:0]    pmin_r;
  logic signed [PROJ_W-1:0]    pmax_r;
  logic [DMIN_W-1:0]           dmin_r;
  logic [SQ_W-1:0]             dmax_r;
  logic [MIN_DIST_W-1:0]       min_dist_r;
  logic [ROOT_W-1:0]           max_dist_r;
  logic                        acc_pend_r;
  logic                        sq_start_r;
  logic                        out_valid_r;

  logic                        cfg_wr;
  logic                        accept;
  logic                        ram_we;
  logic [PTR_W-1:0]            rd_addr;
  logic [2*COORD_W-1:0]        rd_data;
  logic signed [COORD_W-1:0]   rd_x;
  logic signed [COORD_W-1:0]   rd_y;
  logic signed [MUL_W-1:0]     ma0;
  logic signed [MUL_W-1:0]     mb0;
  logic signed [MUL_W-1:0]     ma1;
  logic signed [MUL_W-1:0]     mb1;
  logic signed [PROD_W-1:0]    prod0;
  logic signed [PROD_W-1:0]    prod1;
  logic [SQ_W-1:0]             dist_sum;
  logic [SQ_W-1:0]             sq_operand;
  sq_result_t                  sq_res;

  // Configuration register access.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CFG_AW-1:2] == REG_POINT_COUNT);
  assign prdata = (paddr[CFG_AW-1:2] == REG_POINT_COUNT) ?
                  CFG_DW'(point_count_r) : '0;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Loads go straight into the table; slots past the table end are dropped.
  assign ram_we = accept && (in_op == OP_LOAD) && (int'(in_point_index) < MAX_POINTS);

  // The first point is read while the query is being accepted.
  assign rd_addr = (state_r == S_IDLE) ? '0 : idx_r[PTR_W-1:0];

  pspd_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (PTR_W'(in_point_index)),
    .wdata ({in_point_x, in_point_y}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_x = $signed(rd_data[2*COORD_W-1:COORD_W]);
  assign rd_y = $signed(rd_data[COORD_W-1:0]);

  // Shared multiplier pair: dot product terms in the first pass, squared
  // coordinate differences in the second.
  always_comb begin
    if (state_r == S_MUL1) begin
      ma0 = {rd_x[COORD_W-1], rd_x};
      mb0 = {qx_r[COORD_W-1], qx_r};
      ma1 = {rd_y[COORD_W-1], rd_y};
      mb1 = {qy_r[COORD_W-1], qy_r};
    end else begin
      ma0 = dx_r;
      mb0 = dx_r;
      ma1 = dy_r;
      mb1 = dy_r;
    end
  end

  assign prod0 = ma0 * mb0;
  assign prod1 = ma1 * mb1;

  // Both squares are below 2^32, so their sum fits without sign handling.
  assign dist_sum = prod0_r[SQ_W-1:0] + prod1_r[SQ_W-1:0];

  assign n_nxt = (int'(point_count_r) > MAX_POINTS) ? CNT_W'(MAX_POINTS) :
                 CNT_W'(point_count_r);

  assign sq_operand = (state_r == S_SQMIN) ? SQ_W'(dmin_r) : dmax_r;

  pspd_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start_r),
    .operand (sq_operand),
    .result  (sq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      point_count_r <= '0;
      acc_pend_r    <= 1'b0;
      sq_start_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      sq_start_r  <= 1'b0;
      acc_pend_r  <= 1'b0;
      prod0_r     <= prod0;
      prod1_r     <= prod1;

      if (cfg_wr) begin
        point_count_r <= pwdata[PCNT_W-1:0];
      end

      unique case (state_r)
        S_IDLE: begin
          if (start && (in_op == OP_QUERY)) begin
            qx_r    <= in_query_x;
            qy_r    <= in_query_y;
            n_r     <= n_nxt;
            idx_r   <= '0;
            pmin_r  <= PROJ_START_MIN;
            pmax_r  <= PROJ_START_MAX;
            dmin_r  <= DIST_START_MIN;
            dmax_r  <= '0;
            state_r <= (n_nxt == '0) ? S_DRAIN : S_MUL1;
          end
        end
        S_MUL1: begin
          dx_r    <= $signed({rd_x[COORD_W-1], rd_x}) - $signed({qx_r[COORD_W-1], qx_r});
          dy_r    <= $signed({rd_y[COORD_W-1], rd_y}) - $signed({qy_r[COORD_W-1], qy_r});
          idx_r   <= idx_r + CNT_W'(1);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          proj_r     <= $signed(prod0_r[PROJ_W-1:0]) + $signed(prod1_r[PROJ_W-1:0]);
          acc_pend_r <= 1'b1;
          state_r    <= (idx_r == n_r) ? S_DRAIN : S_MUL1;
        end
        S_DRAIN: begin
          sq_start_r <= 1'b1;
          state_r    <= S_SQMIN;
        end
        S_SQMIN: begin
          if (sq_res.done) begin
            min_dist_r <= sq_res.root[MIN_DIST_W-1:0];
            sq_start_r <= 1'b1;
            state_r    <= S_SQMAX;
          end
        end
        S_SQMAX: begin
          if (sq_res.done) begin
            max_dist_r  <= sq_res.root;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // Running extremes: the cycle after the second pass, the products hold
      // the squared differences and proj_r the dot product of that point.
      if (acc_pend_r) begin
        if (proj_r < pmin_r) begin
          pmin_r <= proj_r;
        end
        if (proj_r > pmax_r) begin
          pmax_r <= proj_r;
        end
        if (dist_sum < SQ_W'(dmin_r)) begin
          dmin_r <= dist_sum[DMIN_W-1:0];
        end
        if (dist_sum > dmax_r) begin
          dmax_r <= dist_sum;
        end
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_proj_lo = pmin_r[MINPROJ_W-1:0];
  assign out_proj_hi = pmax_r;
  assign out_dist_lo = min_dist_r;
  assign out_dist_hi = max_dist_r;

  `PSPD_ASSERT_NEXT(a_query_goes_busy, start && !busy && (in_op == OP_QUERY), busy)
  `PSPD_ASSERT_NEXT(a_result_single_cycle, out_valid, !out_valid)
  `PSPD_ASSERT_IMPL(a_acc_slot, acc_pend_r, (state_r == S_MUL1) || (state_r == S_DRAIN))
  `PSPD_ASSERT_IMPL(a_dist_lo_bound, out_valid, out_dist_lo <= MIN_DIST_LIMIT)
  `PSPD_ASSERT_IMPL(a_proj_lo_bound, out_valid, pmin_r <= PROJ_START_MIN)
  `PSPD_ASSERT_IMPL(a_proj_hi_bound, out_valid, pmax_r >= PROJ_START_MAX)

endmodule

@@ rtl/pspd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the point table; depends on nothing.
`timescale 1ns / 1ps

module pspd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pspd_sqrt.sv @@
// Iterative integer square root, one result bit per cycle, truncating.
// Depends on pspd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "point_set_extreme_projection_distance_macros.svh"

module pspd_sqrt import pspd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SQ_W-1:0] operand,
  output sq_result_t      result
);

  typedef enum logic {SQ_IDLE, SQ_RUN} sq_state_t;

  sq_state_t       state_r;
  logic            done_r;
  logic [SQ_W-1:0] rem_r;
  logic [SQ_W-1:0] root_r;
  logic [SQ_W-1:0] bit_r;
  logic [SQ_W-1:0] trial;

  assign trial = root_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        SQ_IDLE: begin
          if (start) begin
            rem_r   <= operand;
            root_r  <= '0;
            bit_r   <= SQ_BIT0;
            state_r <= SQ_RUN;
          end
        end
        SQ_RUN: begin
          if (rem_r >= trial) begin
            rem_r  <= rem_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            done_r  <= 1'b1;
            state_r <= SQ_IDLE;
          end
        end
        default: state_r <= SQ_IDLE;
      endcase
    end
  end

  assign result.done = done_r;
  assign result.root = root_r[ROOT_W-1:0];

  `PSPD_ASSERT_IMPL(a_sq_bit_onehot, state_r == SQ_RUN, $onehot(bit_r))
  `PSPD_ASSERT_NEXT(a_sq_done_pulse, done_r, !done_r)
  `PSPD_ASSERT_IMPL(a_sq_rem_bound, done_r, rem_r <= (root_r << 1))

endmodule
